// ===== hdl/fjs_pkg.sv =====
// Shared types, codes and constants of the freefall jump statistics block.
`timescale 1ns / 1ps
package fjs_pkg;

  // Input event codes
  localparam logic [2:0] KIND_BEGIN  = 3'd0;
  localparam logic [2:0] KIND_DEPLOY = 3'd1;
  localparam logic [2:0] KIND_TICK   = 3'd2;
  localparam logic [2:0] KIND_FINAL  = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_NONE   = 2'd0;
  localparam logic [1:0] STATUS_RECORD = 2'd1;
  localparam logic [1:0] STATUS_CANCEL = 2'd2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TICK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FF   = 1'd1;
  localparam logic [15:0] MIN_TICK_RESET = 16'd20;
  localparam logic [15:0] MIN_FF_RESET   = 16'd500;

  // Command queue
  localparam int unsigned QUEUE_DEPTH = 2;

  // Speed divider widths: numerator is |dalt|*2000 + dt (< 2^36)
  localparam int unsigned DIV_DVD_W = 36;
  localparam int unsigned DIV_DVS_W = 33;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_DVD_W);

  localparam logic [DIV_DVD_W-1:0] SPEED_SCALE = 36'd2000;
  localparam logic [15:0]          SAT16       = 16'hFFFF;

  // Deciseconds: (ms + 50) / 100 as a multiply by ceil(2^30 / 100).
  // Exact for numerators below 2^23; from DS_SAT_MS on the result saturates.
  localparam logic [22:0]  DS_ROUND  = 23'd50;
  localparam logic [23:0]  DS_RECIP  = 24'd10737419;
  localparam int unsigned  DS_SHIFT  = 30;
  localparam logic [31:0]  DS_SAT_MS = 32'd6553550;

  typedef enum logic [2:0] {
    OP_BEGIN,
    OP_DEPLOY,
    OP_TICK,
    OP_FINAL,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DECI,
    ST_REPORT
  } back_state_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        time_ms;
    logic signed [23:0] altitude_cm;
    logic [31:0]        wall_epoch;
    logic [31:0]        record_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               is_active;
    logic [31:0]        jump_id;
    logic [31:0]        start_epoch;
    logic signed [23:0] exit_height_cm;
    logic signed [23:0] deploy_height_cm;
    logic [15:0]        freefall_ds;
    logic [15:0]        vmax_freefall_cmps;
    logic [15:0]        vmax_canopy_cmps;
    logic               no_time;
  } out_item_t;

  // Classified command held in the queue
  typedef struct packed {
    op_e                op;
    logic [31:0]        time_ms;
    logic signed [23:0] altitude_cm;
    logic [31:0]        wall_epoch;
    logic [31:0]        record_id;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [15:0] min_tick_ms;
    logic [15:0] min_ff_ms;
  } cfg_t;

endpackage

// ===== hdl/fjs_front.sv =====
// Front end: accepts input items, decodes the event kind and pushes commands.
`timescale 1ns / 1ps
module fjs_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  fjs_pkg::in_item_t     in_item_i,
  input  fjs_pkg::queue_stat_t  q_stat_i,
  output logic                  push_o,
  output fjs_pkg::cmd_t         push_cmd_o
);
  import fjs_pkg::*;

  op_e op;

  // Unknown kinds become a no-op that only reports state
  always_comb begin
    unique case (in_item_i.kind)
      KIND_BEGIN:  op = OP_BEGIN;
      KIND_DEPLOY: op = OP_DEPLOY;
      KIND_TICK:   op = OP_TICK;
      KIND_FINAL:  op = OP_FINAL;
      KIND_CLEAR:  op = OP_CLEAR;
      default:     op = OP_NOP;
    endcase
  end

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  assign push_cmd_o.op          = op;
  assign push_cmd_o.time_ms     = in_item_i.time_ms;
  assign push_cmd_o.altitude_cm = in_item_i.altitude_cm;
  assign push_cmd_o.wall_epoch  = in_item_i.wall_epoch;
  assign push_cmd_o.record_id   = in_item_i.record_id;

endmodule

// ===== hdl/fjs_queue.sv =====
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps
module fjs_queue #(
  parameter int unsigned DEPTH = fjs_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fjs_pkg::cmd_t        push_cmd_i,
  input  logic                 pop_i,
  output fjs_pkg::cmd_t        head_o,
  output fjs_pkg::queue_stat_t stat_o
);
  import fjs_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != CNT_W'(DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== hdl/fjs_div.sv =====
// Restoring divider, one quotient bit per cycle, result saturated to 16 bits.
`timescale 1ns / 1ps
module fjs_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [fjs_pkg::DIV_DVD_W-1:0]   dividend_i,
  input  logic [fjs_pkg::DIV_DVS_W-1:0]   divisor_i,
  output logic                            done_o,
  output logic [15:0]                     quot_sat_o
);
  import fjs_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DVD_W-1:0] dvd_q, dvd_d;
  logic [DIV_DVD_W-1:0] quo_q, quo_d;
  logic [DIV_DVS_W-1:0] dvs_q, dvs_d;
  logic [DIV_DVS_W-1:0] rem_q, rem_d;
  logic [DIV_DVS_W:0]   rem_sh;
  logic [DIV_DVS_W:0]   rem_sub;

  // Shift in the next dividend bit and try a subtract
  assign rem_sh  = {rem_q, dvd_q[DIV_DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_DVD_W - 1);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIV_DVD_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[DIV_DVS_W-1:0];
        quo_d = {quo_q[DIV_DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_DVS_W-1:0];
        quo_d = {quo_q[DIV_DVD_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quot_sat_o = (|quo_q[DIV_DVD_W-1:16]) ? SAT16 : quo_q[15:0];

endmodule

// ===== hdl/fjs_back.sv =====
// Back end: executes queued commands on the jump state and drives results.
`timescale 1ns / 1ps
module fjs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fjs_pkg::cfg_t        cfg_i,
  input  fjs_pkg::queue_stat_t q_stat_i,
  input  fjs_pkg::cmd_t        head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fjs_pkg::out_item_t   out_item_o
);
  import fjs_pkg::*;

  back_state_e state_q, state_d;

  // Jump state
  logic               active_q, active_d;
  logic               closed_q, closed_d;
  logic               prev_valid_q, prev_valid_d;
  logic signed [23:0] prev_alt_q, prev_alt_d;
  logic [31:0]        prev_time_q, prev_time_d;
  logic [31:0]        ff_start_q, ff_start_d;
  logic [31:0]        ff_end_q, ff_end_d;
  logic signed [23:0] exit_alt_q, exit_alt_d;
  logic signed [23:0] deploy_alt_q, deploy_alt_d;
  logic [15:0]        peak_ff_q, peak_ff_d;
  logic [15:0]        peak_can_q, peak_can_d;
  logic [31:0]        begin_epoch_q, begin_epoch_d;
  logic [31:0]        active_id_q, active_id_d;

  // Working registers
  cmd_t               cmd_q, cmd_d;
  logic [23:0]        mag_q, mag_d;
  logic [31:0]        dt_q, dt_d;
  logic [31:0]        ff_ms_q, ff_ms_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  // Divider hookup and datapath temporaries
  logic                 div_start;
  logic [DIV_DVD_W-1:0] div_dividend;
  logic [DIV_DVS_W-1:0] div_divisor;
  logic                 div_done;
  logic [15:0]          div_quot;
  logic signed [24:0]   alt_diff;
  logic [24:0]          alt_abs;
  logic [31:0]          dt;
  logic [31:0]          ff_end_eff;
  logic [31:0]          ff_ms;
  logic [15:0]          v_zero_gap;
  logic                 slot_free;
  logic                 cancel;
  logic [22:0]          ds_num;
  logic [46:0]          ds_prod;
  logic [15:0]          ds_val;

  fjs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_sat_o (div_quot)
  );

  // Speed and duration operands
  assign alt_diff   = {cmd_q.altitude_cm[23], cmd_q.altitude_cm} - {prev_alt_q[23], prev_alt_q};
  assign alt_abs    = alt_diff[24] ? 25'(-alt_diff) : 25'(alt_diff);
  assign dt         = cmd_q.time_ms - prev_time_q;
  assign v_zero_gap = (alt_abs != '0) ? SAT16 : 16'd0;
  assign ff_end_eff = closed_q ? ff_end_q : cmd_q.time_ms;
  assign ff_ms      = ff_end_eff - ff_start_q;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign cancel     = (ff_ms_q < {16'd0, cfg_i.min_ff_ms});

  // Freefall time in deciseconds, rounded and saturated
  assign ds_num  = ff_ms_q[22:0] + DS_ROUND;
  assign ds_prod = 47'(ds_num) * 47'(DS_RECIP);
  assign ds_val  = (ff_ms_q >= DS_SAT_MS) ? SAT16 : ds_prod[DS_SHIFT+15:DS_SHIFT];

  // Sequencer: next state, state updates and result formation
  always_comb begin
    state_d       = state_q;
    active_d      = active_q;
    closed_d      = closed_q;
    prev_valid_d  = prev_valid_q;
    prev_alt_d    = prev_alt_q;
    prev_time_d   = prev_time_q;
    ff_start_d    = ff_start_q;
    ff_end_d      = ff_end_q;
    exit_alt_d    = exit_alt_q;
    deploy_alt_d  = deploy_alt_q;
    peak_ff_d     = peak_ff_q;
    peak_can_d    = peak_can_q;
    begin_epoch_d = begin_epoch_q;
    active_id_d   = active_id_q;
    cmd_d         = cmd_q;
    mag_d         = mag_q;
    dt_d          = dt_q;
    ff_ms_d       = ff_ms_q;
    pop_o         = 1'b0;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty && slot_free) begin
          pop_o   = 1'b1;
          cmd_d   = head_i;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_REPORT;
        unique case (cmd_q.op)
          OP_BEGIN: begin
            active_d      = 1'b1;
            closed_d      = 1'b0;
            ff_start_d    = cmd_q.time_ms;
            ff_end_d      = '0;
            exit_alt_d    = cmd_q.altitude_cm;
            deploy_alt_d  = '0;
            peak_ff_d     = '0;
            peak_can_d    = '0;
            prev_valid_d  = 1'b0;
            prev_time_d   = '0;
            begin_epoch_d = cmd_q.wall_epoch;
            active_id_d   = cmd_q.record_id;
          end
          OP_DEPLOY: begin
            if (active_q && !closed_q) begin
              deploy_alt_d = cmd_q.altitude_cm;
              ff_end_d     = cmd_q.time_ms;
              closed_d     = 1'b1;
            end
          end
          OP_TICK: begin
            if (!prev_valid_q) begin
              prev_valid_d = 1'b1;
              prev_alt_d   = cmd_q.altitude_cm;
              prev_time_d  = cmd_q.time_ms;
            end else if (dt >= {16'd0, cfg_i.min_tick_ms}) begin
              prev_alt_d  = cmd_q.altitude_cm;
              prev_time_d = cmd_q.time_ms;
              if (active_q) begin
                if (dt == '0) begin
                  // zero gap: speed is either zero or full scale
                  if (!closed_q) begin
                    if (v_zero_gap > peak_ff_q) peak_ff_d = v_zero_gap;
                  end else begin
                    if (v_zero_gap > peak_can_q) peak_can_d = v_zero_gap;
                  end
                end else begin
                  mag_d   = alt_abs[23:0];
                  dt_d    = dt;
                  state_d = ST_MUL;
                end
              end
            end
          end
          OP_FINAL: begin
            if (active_q) begin
              if (!closed_q) begin
                deploy_alt_d = prev_valid_q ? prev_alt_q : 24'sd0;
                ff_end_d     = cmd_q.time_ms;
                closed_d     = 1'b1;
              end
              ff_ms_d = ff_ms;
              state_d = ST_DECI;
            end
          end
          OP_CLEAR: begin
            active_d      = 1'b0;
            closed_d      = 1'b0;
            prev_valid_d  = 1'b0;
            prev_time_d   = '0;
            begin_epoch_d = '0;
            active_id_d   = '0;
          end
          default: begin
          end
        endcase
      end

      // Rounded speed: (|dalt|*2000 + dt) / (2*dt)
      ST_MUL: begin
        div_start    = 1'b1;
        div_dividend = DIV_DVD_W'(mag_q) * SPEED_SCALE + DIV_DVD_W'(dt_q);
        div_divisor  = {dt_q, 1'b0};
        state_d      = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          if (!closed_q) begin
            if (div_quot > peak_ff_q) peak_ff_d = div_quot;
          end else begin
            if (div_quot > peak_can_q) peak_can_d = div_quot;
          end
          state_d = ST_REPORT;
        end
      end

      // Finalize: the closed jump goes out as a record or a cancellation
      ST_DECI: begin
        out_valid_d                = 1'b1;
        out_d.status               = cancel ? STATUS_CANCEL : STATUS_RECORD;
        out_d.is_active            = 1'b0;
        out_d.jump_id              = cancel ? active_id_q : cmd_q.record_id;
        out_d.start_epoch          = begin_epoch_q;
        out_d.exit_height_cm       = exit_alt_q;
        out_d.deploy_height_cm     = deploy_alt_q;
        out_d.freefall_ds          = ds_val;
        out_d.vmax_freefall_cmps   = peak_ff_q;
        out_d.vmax_canopy_cmps     = peak_can_q;
        out_d.no_time              = !cancel && (begin_epoch_q == '0);
        active_d                   = 1'b0;
        closed_d                   = 1'b0;
        prev_valid_d               = 1'b0;
        prev_time_d                = '0;
        begin_epoch_d              = '0;
        state_d                    = ST_IDLE;
      end

      // Plain result from the state after the item
      ST_REPORT: begin
        out_valid_d                = 1'b1;
        out_d.status               = STATUS_NONE;
        out_d.is_active            = active_q;
        out_d.jump_id              = active_id_q;
        out_d.start_epoch          = begin_epoch_q;
        out_d.exit_height_cm       = exit_alt_q;
        out_d.deploy_height_cm     = deploy_alt_q;
        out_d.freefall_ds          = '0;
        out_d.vmax_freefall_cmps   = peak_ff_q;
        out_d.vmax_canopy_cmps     = peak_can_q;
        out_d.no_time              = 1'b0;
        state_d                    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      active_q      <= 1'b0;
      closed_q      <= 1'b0;
      prev_valid_q  <= 1'b0;
      prev_alt_q    <= '0;
      prev_time_q   <= '0;
      ff_start_q    <= '0;
      ff_end_q      <= '0;
      exit_alt_q    <= '0;
      deploy_alt_q  <= '0;
      peak_ff_q     <= '0;
      peak_can_q    <= '0;
      begin_epoch_q <= '0;
      active_id_q   <= '0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      active_q      <= active_d;
      closed_q      <= closed_d;
      prev_valid_q  <= prev_valid_d;
      prev_alt_q    <= prev_alt_d;
      prev_time_q   <= prev_time_d;
      ff_start_q    <= ff_start_d;
      ff_end_q      <= ff_end_d;
      exit_alt_q    <= exit_alt_d;
      deploy_alt_q  <= deploy_alt_d;
      peak_ff_q     <= peak_ff_d;
      peak_can_q    <= peak_can_d;
      begin_epoch_q <= begin_epoch_d;
      active_id_q   <= active_id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    mag_q   <= mag_d;
    dt_q    <= dt_d;
    ff_ms_q <= ff_ms_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/freefall_jump_statistics_core.sv =====
// Top level of the freefall jump statistics recorder.
`timescale 1ns / 1ps
// Event-driven jump recorder. Each input item (begin, deploy, altitude tick,
// finalize, clear) produces exactly one result item, in order. A front end
// decodes items into a two-entry command queue; a back end executes one
// command at a time against the jump state and holds the result in an output
// register, so input keeps flowing while a result waits. Begin, deploy,
// finalize, clear, unknown kinds and ticks that give no speed go from queue head
// through the execute and report or finalize states to the result; finalize
// scales its duration to deciseconds with a constant reciprocal multiply. A
// tick that yields a speed also runs through a restoring divider that
// produces one quotient bit per cycle over a 36-bit dividend. Configuration
// registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i.
module freefall_jump_statistics_core #(
  parameter int unsigned QUEUE_DEPTH = fjs_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fjs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fjs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  fjs_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output fjs_pkg::out_item_t              out_item_o
);
  import fjs_pkg::*;

  cfg_t        cfg_q, cfg_d;
  queue_stat_t q_stat;
  logic        push;
  cmd_t        push_cmd;
  logic        pop;
  cmd_t        head;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_TICK: cfg_d.min_tick_ms = cfg_wdata_i;
        CFG_MIN_FF:   cfg_d.min_ff_ms   = cfg_wdata_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_tick_ms <= MIN_TICK_RESET;
      cfg_q.min_ff_ms   <= MIN_FF_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fjs_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  fjs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  fjs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // An accepted item is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !q_stat.empty)
    else $error("accepted item missing from queue");

  // A command is taken only when the result slot is free or draining
  a_pop_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!out_valid_o || out_ready_i))
    else $error("command taken while result slot blocked");

  // Commands are executed one at a time
  a_pop_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pop)
    else $error("back end took two commands back to back");

  // No new result right after one is delivered
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> !out_valid_o)
    else $error("result written into a busy slot");

endmodule

// ===== bench/tb_freefall_jump_statistics_core.sv =====
// Self-checking testbench for the freefall jump statistics core.
`timescale 1ns / 1ps
module tb_freefall_jump_statistics_core;
  import fjs_pkg::*;

  // Kind codes the block has to ignore
  localparam logic [2:0] KIND_RESERVED_A = 3'd5;
  localparam logic [2:0] KIND_RESERVED_B = 3'd6;
  localparam logic [2:0] KIND_RESERVED_C = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned ITEMS_PER_PHASE = 125;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              stim_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             result_item;

  freefall_jump_statistics_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (stim_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (result_item)
  );

  always #2 clk_i = ~clk_i;

  // Items waiting to be driven, and records the jump logic should produce
  in_item_t  pending_events[$];
  out_item_t expected_records[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned queued_items = 0;
  int unsigned cycle_count = 0;
  logic [31:0] now_ms = 32'd0;

  // Jump tracker state and its limits
  logic [15:0]        tick_gap_min = MIN_TICK_RESET;
  logic [15:0]        ff_min_ms = MIN_FF_RESET;
  logic               jump_open = 1'b0;
  logic               ff_done = 1'b0;
  logic               sample_ok = 1'b0;
  logic signed [23:0] last_alt = '0;
  logic [31:0]        last_ms = '0;
  logic [31:0]        exit_ms = '0;
  logic [31:0]        close_ms = '0;
  logic signed [23:0] exit_cm = '0;
  logic signed [23:0] deploy_cm = '0;
  logic [15:0]        ff_peak = '0;
  logic [15:0]        canopy_peak = '0;
  logic [31:0]        exit_epoch = '0;
  logic [31:0]        jump_tag = '0;

  function automatic void close_jump();
    jump_open = 1'b0;
    ff_done = 1'b0;
    sample_ok = 1'b0;
    last_ms = '0;
    exit_epoch = '0;
  endfunction

  // Advance the jump tracker by one event and return the record it yields
  function automatic out_item_t step_jump(in_item_t ev);
    out_item_t   r;
    logic [31:0] dt;
    logic [31:0] ff_ms;
    longint      diff;
    logic [63:0] mag;
    logic [63:0] quot;
    logic [63:0] ds;
    logic [15:0] v;
    r = '0;
    case (ev.kind)
      KIND_BEGIN: begin
        jump_open = 1'b1;
        ff_done = 1'b0;
        exit_ms = ev.time_ms;
        close_ms = '0;
        exit_cm = ev.altitude_cm;
        deploy_cm = '0;
        ff_peak = '0;
        canopy_peak = '0;
        sample_ok = 1'b0;
        last_ms = '0;
        exit_epoch = ev.wall_epoch;
        jump_tag = ev.record_id;
      end
      KIND_DEPLOY: begin
        if (jump_open && !ff_done) begin
          deploy_cm = ev.altitude_cm;
          close_ms = ev.time_ms;
          ff_done = 1'b1;
        end
      end
      KIND_TICK: begin
        if (!sample_ok) begin
          sample_ok = 1'b1;
          last_alt = ev.altitude_cm;
          last_ms = ev.time_ms;
        end else begin
          dt = ev.time_ms - last_ms;
          if (dt >= {16'd0, tick_gap_min}) begin
            if (jump_open) begin
              diff = longint'(ev.altitude_cm) - longint'(last_alt);
              mag = (diff < 0) ? -diff : diff;
              // zero gap: any altitude change counts as full-scale speed
              if (dt == 32'd0) begin
                v = (mag != 0) ? 16'hFFFF : 16'd0;
              end else begin
                quot = (mag * 64'd2000 + {32'd0, dt}) / ({32'd0, dt} << 1);
                v = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
              end
              if (!ff_done) begin
                if (v > ff_peak) ff_peak = v;
              end else if (v > canopy_peak) begin
                canopy_peak = v;
              end
            end
            last_alt = ev.altitude_cm;
            last_ms = ev.time_ms;
          end
        end
      end
      KIND_FINAL: begin
        if (jump_open) begin
          // no deploy seen: freefall ends here, at the last sample altitude
          if (!ff_done) begin
            deploy_cm = sample_ok ? last_alt : '0;
            close_ms = ev.time_ms;
            ff_done = 1'b1;
          end
          ff_ms = close_ms - exit_ms;
          ds = ({32'd0, ff_ms} + 64'd50) / 64'd100;
          r.freefall_ds = (ds > 64'd65535) ? 16'hFFFF : ds[15:0];
          if (ff_ms < {16'd0, ff_min_ms}) begin
            r.status = STATUS_CANCEL;
            r.jump_id = jump_tag;
          end else begin
            r.status = STATUS_RECORD;
            r.jump_id = ev.record_id;
            r.no_time = (exit_epoch == 32'd0);
          end
          r.is_active = 1'b0;
          r.start_epoch = exit_epoch;
          r.exit_height_cm = exit_cm;
          r.deploy_height_cm = deploy_cm;
          r.vmax_freefall_cmps = ff_peak;
          r.vmax_canopy_cmps = canopy_peak;
          close_jump();
          return r;
        end
      end
      KIND_CLEAR: begin
        close_jump();
        jump_tag = '0;
      end
      default: ;
    endcase
    r.status = STATUS_NONE;
    r.is_active = jump_open;
    r.jump_id = jump_tag;
    r.start_epoch = exit_epoch;
    r.exit_height_cm = exit_cm;
    r.deploy_height_cm = deploy_cm;
    r.vmax_freefall_cmps = ff_peak;
    r.vmax_canopy_cmps = canopy_peak;
    return r;
  endfunction

  // Driver: predict on acceptance, then present the next item or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) expected_records.push_back(step_jump(stim_item));
      if (!in_valid || in_ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          stim_item <= pending_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Monitor: compare each accepted record with the oldest prediction
  always @(posedge clk_i) begin : record_check
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record %h", result_item);
      end else begin
        want = expected_records.pop_front();
        flag_field("status", want.status, result_item.status);
        flag_field("is_active", want.is_active, result_item.is_active);
        flag_field("jump_id", want.jump_id, result_item.jump_id);
        flag_field("start_epoch", want.start_epoch, result_item.start_epoch);
        flag_field("exit_height_cm", want.exit_height_cm, result_item.exit_height_cm);
        flag_field("deploy_height_cm", want.deploy_height_cm,
                   result_item.deploy_height_cm);
        flag_field("freefall_ds", want.freefall_ds, result_item.freefall_ds);
        flag_field("vmax_freefall_cmps", want.vmax_freefall_cmps,
                   result_item.vmax_freefall_cmps);
        flag_field("vmax_canopy_cmps", want.vmax_canopy_cmps,
                   result_item.vmax_canopy_cmps);
        flag_field("no_time", want.no_time, result_item.no_time);
      end
    end
    out_ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_freefall_jump_statistics_core: done, errors");
      $finish;
    end
  end

  task automatic push_event(input logic [2:0] kind, input logic [31:0] t,
                            input logic [23:0] alt, input logic [31:0] epoch,
                            input logic [31:0] rid);
    in_item_t item;
    item.kind = kind;
    item.time_ms = t;
    item.altitude_cm = alt;
    item.wall_epoch = epoch;
    item.record_id = rid;
    pending_events.push_back(item);
    if (kind <= KIND_CLEAR) queued_items++;
  endtask

  // Move the event clock: mostly short gaps, some long, a few huge
  task automatic advance();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) now_ms += $urandom_range(0, 80);
    else if (r < 95) now_ms += $urandom_range(0, 3000);
    else if (r < 98) now_ms += $urandom_range(0, 200000);
    else now_ms += $urandom;
  endtask

  task automatic push_noise();
    push_event(3'($urandom_range(0, 7)), $urandom, 24'($urandom), $urandom, $urandom);
  endtask

  // One plausible jump: ground samples, exit, freefall, canopy, close
  task automatic queue_jump();
    logic signed [23:0] alt;
    int unsigned        n;
    alt = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(150000, 450000));
    n = $urandom_range(0, 2);
    repeat (n) begin
      advance();
      push_event(KIND_TICK, now_ms, alt, $urandom, $urandom);
    end
    advance();
    push_event(KIND_BEGIN, now_ms, alt, ($urandom_range(3) == 0) ? 32'd0 : $urandom, $urandom);
    n = $urandom_range(0, 6);
    repeat (n) begin
      advance();
      alt = alt + 24'($urandom_range(0, 3000)) - 24'sd2500;
      push_event(KIND_TICK, now_ms, alt, $urandom, $urandom);
    end
    if ($urandom_range(3) != 0) begin
      now_ms += $urandom_range(0, 1500);
      push_event(KIND_DEPLOY, now_ms, alt, $urandom, $urandom);
      if ($urandom_range(5) == 0) begin
        advance();
        push_event(KIND_DEPLOY, now_ms, 24'($urandom), $urandom, $urandom);
      end
      n = $urandom_range(0, 6);
      repeat (n) begin
        advance();
        alt = alt + 24'($urandom_range(0, 400)) - 24'sd300;
        push_event(KIND_TICK, now_ms, alt, $urandom, $urandom);
      end
    end
    if ($urandom_range(7) == 0) push_noise();
    advance();
    if ($urandom_range(9) == 0) push_event(KIND_CLEAR, now_ms, alt, $urandom, $urandom);
    else push_event(KIND_FINAL, now_ms, alt, $urandom, $urandom);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || in_valid || expected_records.size() != 0);
  endtask

  // Register writes happen only with the pipeline empty
  task automatic set_limits(input logic [15:0] tick_ms, input logic [15:0] ff_ms);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MIN_TICK;
    cfg_wdata <= tick_ms;
    @(posedge clk_i);
    cfg_idx <= CFG_MIN_FF;
    cfg_wdata <= ff_ms;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tick_gap_min = tick_ms;
    ff_min_ms = ff_ms;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned goal;
    goal = queued_items + count;
    while (queued_items < goal) begin
      if ($urandom_range(4) == 0) push_noise();
      else queue_jump();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle-state corner cases, extremes and both finalize outcomes
    push_event(KIND_TICK, 32'd100, 24'd0, 32'd0, 32'd0);
    push_event(KIND_TICK, 32'd105, 24'd50, 32'd0, 32'd0);
    push_event(KIND_FINAL, 32'd110, 24'd0, 32'd0, 32'd1);
    push_event(KIND_DEPLOY, 32'd120, 24'd5, 32'd0, 32'd0);
    push_event(KIND_RESERVED_A, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_event(KIND_RESERVED_B, 32'h5555_5555, 24'h80_0000, 32'hAAAA_AAAA, 32'h0);
    push_event(KIND_RESERVED_C, 32'h0, 24'h7F_FFFF, 32'h0, 32'hFFFF_FFFF);
    // exit just before the time counter wraps, with a full-scale altitude swing
    push_event(KIND_BEGIN, 32'hFFFF_FF00, 24'h7F_FFFF, 32'd0, 32'hFFFF_FFFF);
    push_event(KIND_TICK, 32'hFFFF_FF10, 24'h7F_FFFF, 32'd0, 32'd0);
    push_event(KIND_TICK, 32'hFFFF_FF24, 24'h80_0000, 32'd0, 32'd0);
    push_event(KIND_TICK, 32'h0000_0050, 24'h80_0100, 32'd0, 32'd0);
    push_event(KIND_DEPLOY, 32'h0000_0300, 24'd100, 32'd0, 32'd0);
    push_event(KIND_DEPLOY, 32'h0000_0400, 24'd90, 32'd0, 32'd0);
    push_event(KIND_TICK, 32'h0000_0420, 24'd50, 32'd0, 32'd0);
    push_event(KIND_TICK, 32'h0000_0440, 24'd40, 32'd0, 32'd0);
    push_event(KIND_FINAL, 32'h0000_0500, 24'd0, 32'd0, 32'h1234_5678);
    // short freefall with no samples: cancelled
    push_event(KIND_BEGIN, 32'd1000, 24'd1000, 32'hAAAA_5555, 32'd7);
    push_event(KIND_FINAL, 32'd1200, 24'd0, 32'd0, 32'd77);
    // finalize without deploy takes the deploy height from the last sample
    push_event(KIND_BEGIN, 32'd2000, 24'd400000, 32'd1, 32'd8);
    push_event(KIND_TICK, 32'd2100, 24'd399000, 32'd0, 32'd0);
    push_event(KIND_TICK, 32'd2150, 24'd397000, 32'd0, 32'd0);
    push_event(KIND_FINAL, 32'd2700, 24'd0, 32'd0, 32'd88);
    push_event(KIND_BEGIN, 32'd3000, 24'd300000, 32'd3, 32'd9);
    push_event(KIND_CLEAR, 32'd3050, 24'd0, 32'd0, 32'd0);
    push_event(KIND_TICK, 32'd3100, 24'd1, 32'd0, 32'd0);
    push_event(KIND_FINAL, 32'd3200, 24'd0, 32'd0, 32'd0);
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    // Zero limits, idle sender; zero tick gaps become possible
    set_limits(16'd0, 16'd0);
    sender_idle_pct = 52;
    now_ms = $urandom;
    push_event(KIND_BEGIN, now_ms, 24'd5000, 32'd0, 32'd21);
    push_event(KIND_TICK, now_ms, 24'd5000, 32'd0, 32'd0);
    push_event(KIND_TICK, now_ms, 24'd5000, 32'd0, 32'd0);
    push_event(KIND_TICK, now_ms, 24'd4999, 32'd0, 32'd0);
    push_event(KIND_DEPLOY, now_ms, 24'd4999, 32'd0, 32'd0);
    push_event(KIND_TICK, now_ms, 24'd4990, 32'd0, 32'd0);
    push_event(KIND_FINAL, now_ms, 24'd0, 32'd0, 32'd22);
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    // Maximum limits, stalling receiver
    set_limits(16'hFFFF, 16'hFFFF);
    sender_idle_pct = 0;
    recv_stall_pct = 52;
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    // Random limits, both sides idling
    set_limits(16'($urandom_range(0, 200)), 16'($urandom_range(0, 5000)));
    sender_idle_pct = 21;
    recv_stall_pct = 21;
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    set_limits(MIN_TICK_RESET, MIN_FF_RESET);
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("tb_freefall_jump_statistics_core: done, clean");
    end else begin
      $display("tb_freefall_jump_statistics_core: done, errors");
    end
    $finish;
  end

endmodule
